[rtl/sicd_pkg.sv]
package sicd_pkg;

  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned MagWidth    = 15;
  localparam int unsigned PrefixWidth = 6;
  localparam int unsigned PlenWidth   = 3;
  localparam int unsigned SremWidth   = 4;
  localparam int unsigned LenWidth    = 4;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PREFIX = 2'd1,
    PH_SUFFIX = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [PrefixWidth-1:0] prefix_bits;
    logic [PlenWidth-1:0]   prefix_length;
    logic [SremWidth-1:0]   suffix_remaining;
    logic [MagWidth-1:0]    magnitude;
    logic                   negative_flag;
  } sicd_state_t;

  typedef struct packed {
    logic                         emit;
    logic signed [ValueWidth-1:0] value;
  } sicd_result_t;

endpackage

[rtl/sicd_ifs.sv]
interface code_bit_if;
  logic valid;
  logic ready;
  logic code_bit;

  modport source (output valid, output code_bit, input ready);
  modport sink (input valid, input code_bit, output ready);
endinterface

interface decoded_value_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] decoded_value;

  modport source (output valid, output decoded_value, input ready);
  modport sink (input valid, input decoded_value, output ready);
endinterface

[rtl/sicd_step.sv]
module sicd_step
  import sicd_pkg::*;
(
  input  sicd_state_t  cur,
  input  logic         signed_mode,
  input  logic         code_bit,
  output sicd_state_t  nxt,
  output sicd_result_t res
);

  // {hit, len}: complete prefix check on the bits seen so far
  function automatic logic [LenWidth:0] prefix_match(input logic [PrefixWidth-1:0] p,
                                                     input logic [PlenWidth-1:0] l);
    logic [LenWidth:0] r;
    r = '0;
    case (l)
      3'd2: if (p == 6'd0) r = {1'b1, 4'd0};
      3'd3: if (p == 6'd2 || p == 6'd3) r = {1'b1, 4'(p - 6'd1)};
      3'd4: if (p >= 6'd8 && p <= 6'd11) r = {1'b1, 4'(p - 6'd5)};
      3'd5: if (p >= 6'd24 && p <= 6'd30) r = {1'b1, 4'(p - 6'd17)};
      3'd6: r = {1'b1, 3'b111, p[0]};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ValueWidth-1:0] final_value(input logic [MagWidth-1:0] m,
                                                               input logic neg);
    logic [ValueWidth-1:0] v;
    v = {1'b0, m};
    return neg ? ~v : v;
  endfunction

  sicd_state_t          base;
  logic                 skip;
  logic [SremWidth-1:0] sr_dec;
  logic [LenWidth:0]    match;
  logic [LenWidth-1:0]  len;
  logic [LenWidth-1:0]  len_m1;

  always_comb begin
    nxt       = cur;
    res.emit  = 1'b0;
    res.value = final_value(cur.magnitude, cur.negative_flag);
    base      = cur;
    skip      = 1'b0;
    sr_dec    = cur.suffix_remaining - 4'd1;
    match     = '0;
    len       = '0;
    len_m1    = '0;

    unique case (cur.phase)
      PH_SUFFIX: begin
        if (cur.suffix_remaining != '0) begin
          nxt.suffix_remaining = sr_dec;
          nxt.magnitude = cur.magnitude | (MagWidth'(code_bit) << sr_dec);
        end
        if (nxt.suffix_remaining == '0) begin
          res.emit  = 1'b1;
          res.value = final_value(nxt.magnitude, cur.negative_flag);
          nxt       = '{PH_START, '0, '0, '0, '0, cur.negative_flag};
        end
      end
      default: begin
        // start of code: clear, then optionally consume the sign bit
        if (cur.phase != PH_PREFIX) begin
          base = '{PH_PREFIX, '0, '0, '0, '0, 1'b0};
          if (signed_mode) begin
            base.negative_flag = code_bit;
            skip = 1'b1;
          end
        end
        if (skip) begin
          nxt = base;
        end else begin
          nxt = base;
          nxt.prefix_bits   = {base.prefix_bits[PrefixWidth-2:0], code_bit};
          nxt.prefix_length = base.prefix_length + 3'd1;
          match  = prefix_match(nxt.prefix_bits, nxt.prefix_length);
          len    = match[LenWidth-1:0];
          len_m1 = len - 4'd1;
          if (match[LenWidth]) begin
            if (len < 4'd2) begin
              res.emit  = 1'b1;
              res.value = final_value({14'd0, len[0]}, base.negative_flag);
              nxt       = '{PH_START, '0, '0, '0, '0, base.negative_flag};
            end else begin
              nxt.magnitude        = MagWidth'(1) << len_m1;
              nxt.suffix_remaining = len_m1;
              nxt.phase            = PH_SUFFIX;
            end
          end
        end
      end
    endcase
  end

endmodule

[rtl/sicd_core.sv]
module sicd_core
  import sicd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  input  logic         accept,
  input  logic         code_bit,
  output sicd_state_t  state,
  output sicd_result_t res
);

  logic        signed_mode;
  sicd_state_t state_next;

  sicd_step u_step (
    .cur         (state),
    .signed_mode (signed_mode),
    .code_bit    (code_bit),
    .nxt         (state_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
      state       <= '{PH_START, '0, '0, '0, '0, 1'b0};
    end else begin
      if (cfg_wr_en) begin
        signed_mode <= cfg_wr_data;
      end
      if (accept) begin
        state <= state_next;
      end
    end
  end

endmodule

[rtl/sicd_out_stage.sv]
module sicd_out_stage
  import sicd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic signed [ValueWidth-1:0] value,
  decoded_value_if.source        out_ch
);

  logic                         valid;
  logic signed [ValueWidth-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= value;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.decoded_value = data;

endmodule

[rtl/static_integer_code_decoder_top.sv]
// Length-prefixed integer code decoder.
// in_ch carries one code bit per item; out_ch carries one decoded 16-bit
// two's complement value for each completed code. cfg_wr_en/cfg_wr_data
// write signed_mode (1: a sign bit precedes each code); write it only
// while idle, it is sampled at the start of each code.
// Throughput: one code bit per cycle. Each bit passes through one small
// state update between the decoder state register and the output
// register.
// Latency: the value of a code is valid on out_ch in the cycle after the
// item holding its last bit is accepted.
// Stall: the output register holds a finished value while out_ch.ready is
// low, and in_ch.ready stays low as long as that value is held; with the
// register empty, or out_ch.ready high, a bit is taken every cycle.
// Reset (rst, synchronous): clears the decoder state, signed_mode and the
// output valid; decoding restarts at a code boundary.
module static_integer_code_decoder_top
  import sicd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  code_bit_if.sink      in_ch,
  decoded_value_if.source out_ch
);

  logic         accept;
  sicd_state_t  state;
  sicd_result_t res;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  sicd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .code_bit    (in_ch.code_bit),
    .state       (state),
    .res         (res)
  );

  sicd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept && res.emit),
    .value  (res.value),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_suffix_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_SUFFIX |-> state.suffix_remaining != '0)
    else $error("suffix phase with no bits remaining");

  a_prefix_short: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_PREFIX |-> state.prefix_length <= 3'd5)
    else $error("prefix ran past its longest table entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !accept)
    else $error("item taken while a held value is stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid && state.phase == PH_START)
    else $error("output or state not cleared by reset");
`endif

endmodule

[sim/tb_top.sv]
module tb_top
  import sicd_pkg::*;
();

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned DrainCycles = 4;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  code_bit_if      bit_ch ();
  decoded_value_if value_ch ();

  static_integer_code_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (bit_ch),
    .out_ch      (value_ch)
  );

  // decoder mirror
  logic                   signed_mode_mirror;
  phase_t                 code_phase;
  logic [PrefixWidth-1:0] prefix_seen;
  logic [PlenWidth-1:0]   prefix_count;
  logic [SremWidth-1:0]   suffix_left;
  logic [MagWidth-1:0]    magnitude_acc;
  logic                   sign_captured;

  logic signed [ValueWidth-1:0] pending_values[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          quiet;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void restart_code();
    code_phase    = PH_START;
    prefix_seen   = '0;
    prefix_count  = '0;
    suffix_left   = '0;
    magnitude_acc = '0;
  endfunction

  function automatic void push_value();
    logic [ValueWidth-1:0] v;
    v = {1'b0, magnitude_acc};
    pending_values.push_back(sign_captured ? ~v : v);
    restart_code();
  endfunction

  function automatic void decode_bit(input logic b);
    logic             hit;
    logic [LenWidth-1:0] k;
    hit = 1'b0;
    k   = '0;
    if (code_phase == PH_SUFFIX) begin
      if (suffix_left != 0) begin
        suffix_left   = suffix_left - 4'd1;
        magnitude_acc = magnitude_acc | (MagWidth'(b) << suffix_left);
      end
      if (suffix_left == 0) push_value();
      return;
    end
    if (code_phase != PH_PREFIX) begin
      // start of a code: the mode is sampled here only
      restart_code();
      code_phase    = PH_PREFIX;
      sign_captured = signed_mode_mirror ? b : 1'b0;
      if (signed_mode_mirror) return;
    end
    prefix_seen  = {prefix_seen[PrefixWidth-2:0], b};
    prefix_count = prefix_count + 3'd1;
    case (prefix_count)
      3'd2: begin
        hit = (prefix_seen == 6'd0);
        k   = 4'd0;
      end
      3'd3: begin
        hit = (prefix_seen == 6'd2) || (prefix_seen == 6'd3);
        k   = 4'(prefix_seen - 6'd1);
      end
      3'd4: begin
        hit = (prefix_seen >= 6'd8) && (prefix_seen <= 6'd11);
        k   = 4'(prefix_seen - 6'd5);
      end
      3'd5: begin
        hit = (prefix_seen >= 6'd24) && (prefix_seen <= 6'd30);
        k   = 4'(prefix_seen - 6'd17);
      end
      3'd6: begin
        hit = 1'b1;
        k   = 4'd14 + 4'(prefix_seen[0]);
      end
      default: hit = 1'b0;
    endcase
    if (!hit) return;
    if (k < 2) begin
      magnitude_acc = MagWidth'(k);
      push_value();
    end else begin
      magnitude_acc = MagWidth'(1) << (k - 4'd1);
      suffix_left   = k - 4'd1;
      code_phase    = PH_SUFFIX;
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a back-to-back item needs no second assignment
  task automatic send_bit(input logic b);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      bit_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bit_ch.valid    <= 1'b1;
    bit_ch.code_bit <= b;
    do @(posedge clk); while (!bit_ch.ready);
    decode_bit(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_code(input int unsigned k, input logic [MagWidth-1:0] rest,
                           input logic sgn);
    logic [PrefixWidth-1:0] pfx;
    int unsigned            plen;
    if (k == 0) begin
      pfx = 6'd0;  plen = 2;
    end else if (k <= 2) begin
      pfx = 6'(k + 1);  plen = 3;
    end else if (k <= 6) begin
      pfx = 6'(k + 5);  plen = 4;
    end else if (k <= 13) begin
      pfx = 6'(k + 17); plen = 5;
    end else begin
      pfx = 6'(k + 48); plen = 6;
    end
    if (signed_mode_mirror) send_bit(sgn);
    for (int i = int'(plen) - 1; i >= 0; i--) send_bit(pfx[i]);
    for (int i = int'(k) - 2; i >= 0; i--) send_bit(rest[i]);
  endtask

  task automatic drain();
    bit_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    signed_mode_mirror = m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_mode();
    // unsigned by reset: shortest codes and the largest value
    send_code(0, '0, 1'b0);
    send_code(1, '0, 1'b0);
    send_code(15, 15'h7fff, 1'b0);
  endtask

  task automatic test_signed_extremes();
    write_mode(1'b1);
    send_code(15, 15'h7fff, 1'b1);
    send_code(0, '0, 1'b1);
    send_code(2, '0, 1'b0);
    write_mode(1'b0);
    send_code(14, '0, 1'b0);
  endtask

  task automatic test_mode_switch_mid_code();
    // signed code started, mode cleared before it completes
    write_mode(1'b1);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    write_mode(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_code(1, '0, 1'b0);
    // unsigned code started, mode set before it completes
    send_bit(1'b0);
    send_bit(1'b1);
    write_mode(1'b1);
    send_bit(1'b0);
    send_code(1, '0, 1'b1);
  endtask

  task automatic test_random_stream();
    int unsigned target;
    int unsigned run;
    for (int p = 0; p < 6; p++) begin
      write_mode((p == 0 || p == 5) ? 1'b1 : 1'(p[0] ^ $urandom_range(0, 1)));
      quiet  = (p == 2);
      target = items_sent + RandomItems / 6;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          send_code($urandom_range(0, 15), 15'($urandom), 1'($urandom));
        end else begin
          run = $urandom_range(1, 8);
          repeat (run) send_bit(1'($urandom));
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    bit_ch.valid       = 1'b0;
    bit_ch.code_bit    = 1'b0;
    signed_mode_mirror = 1'b0;
    sign_captured      = 1'b0;
    restart_code();
    mismatches = 0;
    items_sent = 0;
    quiet      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_mode();
    test_signed_extremes();
    test_mode_switch_mid_code();
    test_random_stream();
    drain();

    if (mismatches == 0) begin
      $display("static_integer_code_decoder_top: match");
    end else begin
      $display("static_integer_code_decoder_top: mismatch");
    end
    $finish;
  end

  initial begin
    int unsigned n;
    value_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      n = idle_len();
      if (n > 0) begin
        value_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      value_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    logic signed [ValueWidth-1:0] want;
    if (!rst && value_ch.valid && value_ch.ready) begin
      if (pending_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected decoded_value %0d, nothing pending", value_ch.decoded_value);
      end else begin
        want = pending_values.pop_front();
        if (value_ch.decoded_value !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("decoded_value: expected %0d, got %0d", want, value_ch.decoded_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("static_integer_code_decoder_top: mismatch");
      $finish;
    end
  end

endmodule
